// ===== design/gf2m_pkg.sv =====
package gf2m_pkg;

  // Field size and the low part of the reduction polynomial x^128 + x^7 + x^2 + x + 1
  localparam int Width = 128;
  localparam int HalfWidth = 64;
  localparam logic [Width-1:0] PolyLow = 128'h87;

  // Configuration register indexes
  localparam int CfgIndexWidth = 8;
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SCALAR_LOW  = 8'd0,
    REG_SCALAR_HIGH = 8'd1
  } cfg_reg_t;

  typedef logic [Width-1:0] field_t;

  // Data handed from one cell to the next
  typedef struct packed {
    field_t acc;
    field_t elem;
  } cell_data_t;

  // Multiply a field element by x and reduce
  function automatic field_t mul_x(input field_t a);
    field_t shifted;
    shifted = {a[Width-2:0], 1'b0};
    return a[Width-1] ? (shifted ^ PolyLow) : shifted;
  endfunction

endpackage

// ===== design/gf2m_elem_if.sv =====
interface gf2m_elem_if;
  import gf2m_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HalfWidth-1:0] element_low;
  logic [HalfWidth-1:0] element_high;

  modport source (output valid, element_low, element_high, input ready);
  modport sink   (input valid, element_low, element_high, output ready);
endinterface

// ===== design/gf2m_prod_if.sv =====
interface gf2m_prod_if;
  import gf2m_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HalfWidth-1:0] product_low;
  logic [HalfWidth-1:0] product_high;

  modport source (output valid, product_low, product_high, input ready);
  modport sink   (input valid, product_low, product_high, output ready);
endinterface

// ===== design/gf2m_cfg_if.sv =====
interface gf2m_cfg_if;
  import gf2m_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [HalfWidth-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/gf2_128_scalar_multiply.sv =====
// GF(2^128) scalar multiplier: each item (element_low/element_high, bit k is the
// coefficient of x^k) is multiplied by the scalar in registers scalar_low (index 0)
// and scalar_high (index 1), reduced modulo x^128 + x^7 + x^2 + x + 1. The work runs
// through a row of 128/CELL_BITS cells, each doing CELL_BITS multiply-by-x-and-add
// steps on the scalar bits, top bit first. A new item is taken every cycle unless the
// row is stalled; each item passes through the cells in turn, each cell ending in a
// register. The whole row stalls while a result waits at the output.
// Write the scalar only when no item is in flight; both registers reset to zero.
module gf2_128_scalar_multiply import gf2m_pkg::*; #(
  parameter int CELL_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  gf2m_cfg_if.sink     cfg,
  gf2m_elem_if.sink    elem,
  gf2m_prod_if.source  prod
);

  localparam int NumCells = Width / CELL_BITS;

  logic [HalfWidth-1:0] scalar_low;
  logic [HalfWidth-1:0] scalar_high;
  field_t               scalar;
  logic                 adv;

  logic       cell_valid [NumCells+1];
  cell_data_t cell_data  [NumCells+1];

  // Configuration registers; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_low  <= '0;
      scalar_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SCALAR_LOW:  scalar_low  <= cfg.data;
        REG_SCALAR_HIGH: scalar_high <= cfg.data;
        default: ;
      endcase
    end
  end

  assign scalar = {scalar_high, scalar_low};

  // Row advances unless the last cell holds a result nobody takes
  assign adv        = !cell_valid[NumCells] || prod.ready;
  assign elem.ready = adv;

  // Head of the row: fresh accumulator
  assign cell_valid[0]     = elem.valid;
  assign cell_data[0].acc  = '0;
  assign cell_data[0].elem = {elem.element_high, elem.element_low};

  // Row of cells
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    gf2m_cell #(
      .CELL_BITS (CELL_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (adv),
      .valid_in    (cell_valid[c]),
      .data_in     (cell_data[c]),
      .scalar_bits (scalar[Width-1-c*CELL_BITS -: CELL_BITS]),
      .valid_out   (cell_valid[c+1]),
      .data_out    (cell_data[c+1])
    );
  end

  // Last cell is the output register
  assign prod.valid        = cell_valid[NumCells];
  assign prod.product_low  = cell_data[NumCells].acc[HalfWidth-1:0];
  assign prod.product_high = cell_data[NumCells].acc[Width-1:HalfWidth];

  // Checks
  a_accept_enters_row: assert property (@(posedge clk) disable iff (rst)
    (elem.valid && elem.ready) |=> cell_valid[1])
    else $error("accepted item did not enter the first cell");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (cell_valid[NumCells] && $stable(cell_data[NumCells].acc)))
    else $error("result changed while stalled");

  a_cfg_low: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.index == REG_SCALAR_LOW) |=> scalar_low == $past(cfg.data))
    else $error("scalar_low write lost");

  a_cfg_high: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.index == REG_SCALAR_HIGH) |=> scalar_high == $past(cfg.data))
    else $error("scalar_high write lost");

endmodule

// ===== design/gf2m_cell.sv =====
module gf2m_cell import gf2m_pkg::*; #(
  parameter int CELL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  cell_data_t           data_in,
  input  logic [CELL_BITS-1:0] scalar_bits,
  output logic                 valid_out,
  output cell_data_t           data_out
);

  cell_data_t data_next;

  // Horner steps, most significant scalar bit first: acc = acc*x + bit*elem
  always_comb begin
    field_t acc_v;
    acc_v = data_in.acc;
    for (int j = CELL_BITS - 1; j >= 0; j--) begin
      acc_v = mul_x(acc_v) ^ (scalar_bits[j] ? data_in.elem : '0);
    end
    data_next.acc  = acc_v;
    data_next.elem = data_in.elem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import gf2m_pkg::*;

  // Reduction taps: x^128 folds onto x^7, x^2, x^1 and x^0
  localparam int ProdBits = 2 * Width - 1;
  localparam int Tap7 = Width - 7;
  localparam int Tap2 = Width - 2;
  localparam int Tap1 = Width - 1;

  // A register index that maps to nothing; writes to it must be dropped
  localparam logic [CfgIndexWidth-1:0] UnusedIndex = 8'd5;

  localparam field_t AllOnes = {Width{1'b1}};
  localparam field_t FieldOne = field_t'(1);
  localparam field_t TopBit = FieldOne << (Width - 1);
  localparam field_t LowHalfMask = {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}};

  // Receiver stall patterns
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst;

  gf2m_cfg_if  cfg_bus ();
  gf2m_elem_if elem_bus ();
  gf2m_prod_if prod_bus ();

  gf2_128_scalar_multiply dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus),
    .elem (elem_bus),
    .prod (prod_bus)
  );

  // Testbench copy of the scalar registers
  field_t   scalar_shadow;
  field_t   product_queue[$];
  int       fail_count;
  int       burst_left;
  int       gap_max;
  rx_mode_t rx_mode;
  int       rx_cycle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Scalar times element: carry-less product, then fold from the top coefficient down
  function automatic field_t gf128_scale(input field_t elem, input field_t scalar);
    logic [ProdBits-1:0] wide;
    wide = '0;
    for (int k = 0; k < Width; k++) begin
      if (scalar[k]) begin
        wide ^= {{(Width - 1){1'b0}}, elem} << k;
      end
    end
    for (int k = ProdBits - 1; k >= Width; k--) begin
      if (wide[k]) begin
        wide[k]        = 1'b0;
        wide[k - Tap7] ^= 1'b1;
        wide[k - Tap2] ^= 1'b1;
        wide[k - Tap1] ^= 1'b1;
        wide[k - Width] ^= 1'b1;
      end
    end
    return wide[Width-1:0];
  endfunction

  // One register write; valid is left high for a following write
  task automatic write_cfg(input logic [CfgIndexWidth-1:0] idx, input logic [HalfWidth-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_SCALAR_LOW:  scalar_shadow[HalfWidth-1:0] = val;
      REG_SCALAR_HIGH: scalar_shadow[Width-1:HalfWidth] = val;
      default: ;
    endcase
  endtask

  task automatic set_scalar(input field_t s);
    write_cfg(REG_SCALAR_LOW, s[HalfWidth-1:0]);
    write_cfg(REG_SCALAR_HIGH, s[Width-1:HalfWidth]);
    cfg_bus.valid <= 1'b0;
  endtask

  // Send one item; between bursts the sender drops valid for a random gap
  task automatic send_element(input field_t e);
    elem_bus.valid        <= 1'b1;
    elem_bus.element_low  <= e[HalfWidth-1:0];
    elem_bus.element_high <= e[Width-1:HalfWidth];
    do @(posedge clk); while (!elem_bus.ready);
    product_queue.push_back(gf128_scale(e, scalar_shadow));
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      burst_left = $urandom_range(0, 12);
      elem_bus.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  task automatic drain_products();
    elem_bus.valid <= 1'b0;
    while (product_queue.size() != 0) @(posedge clk);
  endtask

  function automatic field_t random_field();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Mostly dense random elements, with one-hot, all-ones and zero mixed in
  function automatic field_t random_element();
    case ($urandom_range(0, 9))
      0:       return FieldOne << $urandom_range(0, Width - 1);
      1:       return AllOnes;
      2:       return '0;
      default: return random_field();
    endcase
  endfunction

  function automatic field_t random_scalar();
    case ($urandom_range(0, 5))
      0:       return FieldOne << $urandom_range(0, Width - 1);
      1:       return AllOnes;
      2:       return random_field() & LowHalfMask;
      3:       return random_field() << HalfWidth;
      default: return random_field();
    endcase
  endfunction

  // Scalar left at reset value: every product is zero
  task automatic test_reset_scalar();
    send_element(AllOnes);
    send_element(random_field());
    send_element(TopBit);
    drain_products();
  endtask

  // Scalar one: product equals the element
  task automatic test_identity();
    set_scalar(FieldOne);
    send_element('0);
    send_element(AllOnes);
    send_element(FieldOne);
    send_element(TopBit);
    send_element(FieldOne << (HalfWidth - 1));
    send_element(FieldOne << HalfWidth);
    drain_products();
  endtask

  // Top coefficients: products reach x^254 and need the full fold
  task automatic test_top_coefficients();
    set_scalar(TopBit);
    send_element(TopBit);
    send_element(AllOnes);
    send_element(FieldOne << 1);
    drain_products();
    set_scalar(AllOnes);
    send_element(AllOnes);
    send_element({Width / 4{4'b1010}});
    send_element({Width / 4{4'b0101}});
    send_element(TopBit);
    drain_products();
  endtask

  // A write to an index past the last register must leave the scalar alone
  task automatic test_unused_index();
    set_scalar({HalfWidth{2'b01}} >> HalfWidth | (field_t'(64'h0123_4567_89ab_cdef) << HalfWidth));
    @(posedge clk);
    write_cfg(UnusedIndex, {HalfWidth{1'b1}});
    cfg_bus.valid <= 1'b0;
    send_element(random_field());
    send_element(AllOnes);
    drain_products();
  endtask

  // Random streams over several scalars, with varied sender and receiver pacing
  task automatic test_random_stream();
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0 || phase == 5) begin
        rx_mode = RX_ALWAYS;
        gap_max = 0;
      end else begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        gap_max = $urandom_range(0, 20);
      end
      if (phase == 9) set_scalar('0);
      else set_scalar(random_scalar());
      for (int n = 0; n < 125; n++) begin
        send_element(random_element());
      end
      drain_products();
    end
  endtask

  // Receiver ready pattern
  initial begin
    prod_bus.ready <= 1'b0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      case (rx_mode)
        RX_ALWAYS:   prod_bus.ready <= 1'b1;
        RX_RANDOM:   prod_bus.ready <= ($urandom_range(0, 2) != 0);
        RX_PERIODIC: prod_bus.ready <= ((rx_cycle % 11) < 6);
        default:     prod_bus.ready <= 1'b1;
      endcase
    end
  end

  // Compare each accepted product with the oldest expectation
  always @(posedge clk) begin
    field_t want;
    if (!rst && prod_bus.valid && prod_bus.ready) begin
      if (product_queue.size() == 0) begin
        fail_count++;
        $display("%0t: product with nothing expected, actual %h_%h", $time,
                 prod_bus.product_high, prod_bus.product_low);
      end else begin
        want = product_queue.pop_front();
        if (prod_bus.product_low !== want[HalfWidth-1:0]) begin
          fail_count++;
          $display("%0t: product_low expected %h actual %h", $time,
                   want[HalfWidth-1:0], prod_bus.product_low);
        end
        if (prod_bus.product_high !== want[Width-1:HalfWidth]) begin
          fail_count++;
          $display("%0t: product_high expected %h actual %h", $time,
                   want[Width-1:HalfWidth], prod_bus.product_high);
        end
      end
    end
  end

  initial begin
    fail_count    = 0;
    burst_left    = 0;
    gap_max       = 4;
    rx_mode       = RX_RANDOM;
    scalar_shadow = '0;
    rst                   <= 1'b1;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= '0;
    cfg_bus.data          <= '0;
    elem_bus.valid        <= 1'b0;
    elem_bus.element_low  <= '0;
    elem_bus.element_high <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_scalar();
    test_identity();
    test_top_coefficients();
    test_unused_index();
    test_random_stream();

    repeat (40) @(posedge clk);
    if (product_queue.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
